/* sv/lennard_jones_pair_force_unit_assert.svh */
// Assertion macros for the pair force unit.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef LENNARD_JONES_PAIR_FORCE_UNIT_ASSERT_SVH
`define LENNARD_JONES_PAIR_FORCE_UNIT_ASSERT_SVH

// same-cycle implication
`define LJPF_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define LJPF_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* sv/ljpf_pkg.sv */
// Shared types and constants of the pair force unit.
// No dependencies.
package ljpf_pkg;

  localparam logic signed [63:0] WMAX = 64'sh7FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic start;
    logic frac_shift;
  } mul_req_t;

  typedef struct packed {
    logic start;
    logic recip;
  } div_req_t;

endpackage

/* sv/lennard_jones_pair_force_unit.sv */
// Lennard-Jones pair force unit: a load item writes the position RAM; a query walks
// n slots and uses the bit-serial divider (minimum image and reciprocal) and the
// four-pass shared 32x32 multiplier, doing more work for a kept pair than for a
// dropped one. One item at a time.
// Reset clears configuration to defaults; the position RAM is not cleared.
// Depends on ljpf_pkg, ljpf_ram, ljpf_mul, ljpf_div and lennard_jones_pair_force_unit_assert.svh.
module lennard_jones_pair_force_unit import ljpf_pkg::*; #(
  parameter int MAX_PARTICLES = 1024,
  parameter int FRAC_BITS     = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                kind_i,
  input  logic [9:0]          index_i,
  input  logic signed [31:0]  pos_x_i,
  input  logic signed [31:0]  pos_y_i,
  input  logic signed [31:0]  pos_z_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [47:0]  force_x_o,
  output logic signed [47:0]  force_y_o,
  output logic signed [47:0]  force_z_o,
  output logic signed [47:0]  energy_o,
  output logic                status_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i
);

`include "lennard_jones_pair_force_unit_assert.svh"

  localparam int AW    = $clog2(MAX_PARTICLES);
  localparam int CW    = $clog2(MAX_PARTICLES + 1);
  localparam int NUM_W = 33 + 2 * FRAC_BITS;
  localparam int IW    = $clog2(NUM_W + 1);

  localparam logic [2:0] CFG_PCOUNT = 3'd0;
  localparam logic [2:0] CFG_RCOUNT = 3'd1;
  localparam logic [2:0] CFG_BOX    = 3'd2;
  localparam logic [2:0] CFG_CUT    = 3'd3;
  localparam logic [2:0] CFG_EPS    = 3'd4;
  localparam logic [2:0] CFG_SHIFT  = 3'd5;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LATCH_I, ST_RD_J, ST_GET_J, ST_AXIS, ST_DIV_WAIT, ST_SQ_GO,
    ST_SQ_WAIT, ST_CHECK, ST_RCP_WAIT, ST_MUL_GO, ST_MUL_WAIT, ST_NEXT, ST_RESULT
  } state_e;

  typedef enum logic [3:0] {
    MS_T, MS_INV6, MS_INV12, MS_A, MS_FR, MS_E, MS_FX, MS_FY, MS_FZ
  } step_e;

  function automatic logic signed [63:0] sadd(logic signed [63:0] a,
                                              logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'(WMAX)) return WMAX;
    if (s < -65'(WMAX)) return -WMAX;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] shr9(logic signed [63:0] v);
    logic [63:0] m;
    m = v[63] ? 64'(-v) : 64'(v);
    m = m >> 9;
    return v[63] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [47:0] clamp48(logic signed [63:0] v);
    if (v > 64'sh7FFF_FFFF_FFFF) return 48'sh7FFF_FFFF_FFFF;
    if (v < -64'sh8000_0000_0000) return 48'sh8000_0000_0000;
    return v[47:0];
  endfunction

  state_e             state_q;
  step_e              step_q;
  logic [10:0]        pcount_q, rcount_q;
  logic [30:0]        box_q, cut_q, eps_q;
  logic signed [31:0] shift_q;
  logic               rej_q, dneg_q;
  logic [CW-1:0]      j_q, n_q;
  logic [1:0]         axis_q;
  logic [31:0]        pi_q [3];
  logic [31:0]        pj_q [3];
  logic signed [32:0] dv_q [3];
  logic [63:0]        r2_q;
  logic signed [63:0] inv2_q, tmp_q, inv6_q, inv12_q, b_q, c_q, fr_q, e_q;
  logic signed [63:0] fx_q, fy_q, fz_q, pe_q;
  logic               out_valid_q, status_q;
  logic signed [47:0] fxo_q, fyo_q, fzo_q, peo_q;

  logic               in_acc, out_load, ram_we;
  logic [AW-1:0]      ram_raddr;
  logic [95:0]        ram_rdata;
  logic signed [32:0] d_cur, dm;
  logic signed [63:0] eps24, eps4, shift_w, mul_a, mul_b;
  logic [63:0]        rc;
  mul_req_t           mul_req;
  div_req_t           div_req;
  logic [NUM_W-1:0]   div_num;
  logic [IW-1:0]      div_iters;
  logic [63:0]        div_den;
  logic               mul_busy, mul_done, div_busy, div_done, div_ovf;
  logic signed [63:0] mul_res;
  logic [63:0]        mul_lo, div_quo, div_rem;
  logic [30:0]        rm, wmag;
  logic               round_up, wneg, keep;
  logic [CW-1:0]      n_w;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign ram_we      = in_acc && !kind_i && (32'(index_i) < MAX_PARTICLES);
  assign out_load    = (state_q == ST_RESULT) && (!out_valid_q || !out_stall_i);

  always_comb begin
    eps24    = $signed((64'(eps_q) << (32 - FRAC_BITS)) * 64'd24);
    eps4     = $signed(64'(eps_q) << (34 - FRAC_BITS));
    shift_w  = 64'(shift_q) <<< (32 - FRAC_BITS);
    rc       = 64'(cut_q) << FRAC_BITS;
    n_w      = (32'(pcount_q) > MAX_PARTICLES) ? CW'(MAX_PARTICLES) : CW'(pcount_q);
    ram_raddr = (state_q == ST_IDLE) ? AW'(index_i) : j_q[AW-1:0];
    d_cur    = $signed({pi_q[axis_q][31], pi_q[axis_q]})
             - $signed({pj_q[axis_q][31], pj_q[axis_q]});
    dm       = d_cur[32] ? -d_cur : d_cur;
    rm       = div_rem[30:0];
    round_up = ({rm, 1'b0} > {1'b0, box_q}) || (({rm, 1'b0} == {1'b0, box_q}) && div_quo[0]);
    wmag     = round_up ? (box_q - rm) : rm;
    wneg     = round_up ? !dneg_q : dneg_q;
    keep     = (r2_q != 64'd0) && (r2_q < rc);

    div_req.start = ((state_q == ST_AXIS) && (box_q != '0))
                 || ((state_q == ST_CHECK) && keep);
    div_req.recip = (state_q == ST_CHECK);
    if (div_req.recip) begin
      div_num   = {1'b1, (NUM_W-1)'(0)};
      div_iters = IW'(NUM_W);
      div_den   = r2_q;
    end else begin
      div_num   = {dm[31:0], (NUM_W-32)'(0)};
      div_iters = IW'(32);
      div_den   = 64'(box_q);
    end

    mul_req.start      = (state_q == ST_SQ_GO) || (state_q == ST_MUL_GO);
    mul_req.frac_shift = (state_q == ST_MUL_GO) &&
                         ((step_q == MS_FX) || (step_q == MS_FY) || (step_q == MS_FZ));
    mul_a = 64'(dv_q[axis_q]);
    mul_b = 64'(dv_q[axis_q]);
    if (state_q == ST_MUL_GO) begin
      case (step_q)
        MS_T:     begin mul_a = inv2_q;  mul_b = inv2_q;   end
        MS_INV6:  begin mul_a = tmp_q;   mul_b = inv2_q;   end
        MS_INV12: begin mul_a = inv6_q;  mul_b = inv6_q;   end
        MS_A:     begin mul_a = eps24;   mul_b = inv2_q;   end
        MS_FR:    begin mul_a = tmp_q;   mul_b = b_q;      end
        MS_E:     begin mul_a = eps4;    mul_b = c_q;      end
        MS_FX:    begin mul_a = fr_q;    mul_b = 64'(dv_q[0]); end
        MS_FY:    begin mul_a = fr_q;    mul_b = 64'(dv_q[1]); end
        MS_FZ:    begin mul_a = fr_q;    mul_b = 64'(dv_q[2]); end
        default:  begin mul_a = '0;      mul_b = '0;       end
      endcase
    end
  end

  ljpf_ram #(.WIDTH(96), .DEPTH(MAX_PARTICLES)) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AW'(index_i)),
    .wdata_i ({pos_z_i, pos_y_i, pos_x_i}),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  ljpf_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (mul_req),
    .a_i       (mul_a),
    .b_i       (mul_b),
    .busy_o    (mul_busy),
    .done_o    (mul_done),
    .res_o     (mul_res),
    .prod_lo_o (mul_lo)
  );

  ljpf_div #(.NUM_W(NUM_W)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (div_req),
    .num_i   (div_num),
    .iters_i (div_iters),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quo_o   (div_quo),
    .ovf_o   (div_ovf),
    .rem_o   (div_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= MS_T;
      pcount_q    <= '0;
      rcount_q    <= '0;
      box_q       <= 31'd655360;
      cut_q       <= 31'd409600;
      eps_q       <= 31'd65536;
      shift_q     <= '0;
      rej_q       <= 1'b0;
      dneg_q      <= 1'b0;
      j_q         <= '0;
      n_q         <= '0;
      axis_q      <= '0;
      pi_q        <= '{default: '0};
      pj_q        <= '{default: '0};
      dv_q        <= '{default: '0};
      r2_q        <= '0;
      inv2_q      <= '0;
      tmp_q       <= '0;
      inv6_q      <= '0;
      inv12_q     <= '0;
      b_q         <= '0;
      c_q         <= '0;
      fr_q        <= '0;
      e_q         <= '0;
      fx_q        <= '0;
      fy_q        <= '0;
      fz_q        <= '0;
      pe_q        <= '0;
      out_valid_q <= 1'b0;
      status_q    <= 1'b0;
      fxo_q       <= '0;
      fyo_q       <= '0;
      fzo_q       <= '0;
      peo_q       <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_PCOUNT: pcount_q <= cfg_data_i[10:0];
          CFG_RCOUNT: rcount_q <= cfg_data_i[10:0];
          CFG_BOX:    box_q    <= cfg_data_i[30:0];
          CFG_CUT:    cut_q    <= cfg_data_i[30:0];
          CFG_EPS:    eps_q    <= cfg_data_i[30:0];
          CFG_SHIFT:  shift_q  <= $signed(cfg_data_i);
          default:    ;
        endcase
      end

      if (out_valid_q && !out_stall_i && (state_q != ST_RESULT)) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_acc && kind_i) begin
            rej_q <= ({1'b0, index_i} >= rcount_q) || (32'(index_i) >= MAX_PARTICLES);
            fx_q  <= '0;
            fy_q  <= '0;
            fz_q  <= '0;
            pe_q  <= '0;
            j_q   <= '0;
            n_q   <= n_w;
            if (({1'b0, index_i} >= rcount_q) || (32'(index_i) >= MAX_PARTICLES)) begin
              state_q <= ST_RESULT;
            end else begin
              state_q <= ST_LATCH_I;
            end
          end
        end
        ST_LATCH_I: begin
          pi_q[0] <= ram_rdata[31:0];
          pi_q[1] <= ram_rdata[63:32];
          pi_q[2] <= ram_rdata[95:64];
          state_q <= (n_q == '0) ? ST_RESULT : ST_RD_J;
        end
        ST_RD_J: begin
          state_q <= ST_GET_J;
        end
        ST_GET_J: begin
          pj_q[0] <= ram_rdata[31:0];
          pj_q[1] <= ram_rdata[63:32];
          pj_q[2] <= ram_rdata[95:64];
          axis_q  <= '0;
          state_q <= ST_AXIS;
        end
        ST_AXIS: begin
          dneg_q <= d_cur[32];
          if (box_q == '0) begin
            dv_q[axis_q] <= d_cur;
            if (axis_q == 2'd2) begin
              axis_q  <= '0;
              r2_q    <= '0;
              state_q <= ST_SQ_GO;
            end else begin
              axis_q <= axis_q + 2'd1;
            end
          end else begin
            state_q <= ST_DIV_WAIT;
          end
        end
        ST_DIV_WAIT: begin
          if (div_done) begin
            dv_q[axis_q] <= wneg ? -$signed({2'b00, wmag}) : $signed({2'b00, wmag});
            if (axis_q == 2'd2) begin
              axis_q  <= '0;
              r2_q    <= '0;
              state_q <= ST_SQ_GO;
            end else begin
              axis_q  <= axis_q + 2'd1;
              state_q <= ST_AXIS;
            end
          end
        end
        ST_SQ_GO: begin
          state_q <= ST_SQ_WAIT;
        end
        ST_SQ_WAIT: begin
          if (mul_done) begin
            r2_q <= r2_q + mul_lo;
            if (axis_q == 2'd2) begin
              state_q <= ST_CHECK;
            end else begin
              axis_q  <= axis_q + 2'd1;
              state_q <= ST_SQ_GO;
            end
          end
        end
        ST_CHECK: begin
          state_q <= keep ? ST_RCP_WAIT : ST_NEXT;
        end
        ST_RCP_WAIT: begin
          if (div_done) begin
            inv2_q  <= (div_ovf || div_quo[63]) ? WMAX : $signed(div_quo);
            step_q  <= MS_T;
            state_q <= ST_MUL_GO;
          end
        end
        ST_MUL_GO: begin
          if (step_q == MS_FX) begin
            pe_q <= sadd(pe_q, shr9(e_q));
          end
          state_q <= ST_MUL_WAIT;
        end
        ST_MUL_WAIT: begin
          if (mul_done) begin
            state_q <= ST_MUL_GO;
            case (step_q)
              MS_T:     begin tmp_q <= mul_res; step_q <= MS_INV6; end
              MS_INV6:  begin inv6_q <= mul_res; step_q <= MS_INV12; end
              MS_INV12: begin inv12_q <= mul_res; step_q <= MS_A; end
              MS_A: begin
                tmp_q  <= mul_res;
                b_q    <= sadd(sadd(inv12_q, inv12_q), -inv6_q);
                c_q    <= sadd(inv12_q, -inv6_q);
                step_q <= MS_FR;
              end
              MS_FR:    begin fr_q <= mul_res; step_q <= MS_E; end
              MS_E:     begin e_q <= sadd(mul_res, -shift_w); step_q <= MS_FX; end
              MS_FX:    begin fx_q <= sadd(fx_q, mul_res); step_q <= MS_FY; end
              MS_FY:    begin fy_q <= sadd(fy_q, mul_res); step_q <= MS_FZ; end
              MS_FZ: begin
                fz_q    <= sadd(fz_q, mul_res);
                state_q <= ST_NEXT;
              end
              default:  state_q <= ST_NEXT;
            endcase
          end
        end
        ST_NEXT: begin
          if (CW'(j_q + 1'b1) == n_q) begin
            state_q <= ST_RESULT;
          end else begin
            j_q     <= CW'(j_q + 1'b1);
            state_q <= ST_RD_J;
          end
        end
        ST_RESULT: begin
          if (out_load) begin
            out_valid_q <= 1'b1;
            status_q    <= rej_q;
            fxo_q       <= rej_q ? '0 : clamp48(fx_q);
            fyo_q       <= rej_q ? '0 : clamp48(fy_q);
            fzo_q       <= rej_q ? '0 : clamp48(fz_q);
            peo_q       <= rej_q ? '0 : clamp48(pe_q);
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign force_x_o   = fxo_q;
  assign force_y_o   = fyo_q;
  assign force_z_o   = fzo_q;
  assign energy_o    = peo_q;

  `LJPF_ASSERT_IMP(a_mul_free, mul_req.start, !mul_busy)
  `LJPF_ASSERT_IMP(a_div_free, div_req.start, !div_busy)
  `LJPF_ASSERT_IMP(a_out_free, out_load, !(out_valid_q && out_stall_i))
  `LJPF_ASSERT_NXT(a_query_busy, in_acc && kind_i, in_stall_o)

endmodule

/* sv/ljpf_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ljpf_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* sv/ljpf_mul.sv */
// Multi-cycle signed 64x64 multiplier on one 32x32 unit, shifted,
// truncated toward zero and saturated. Depends on ljpf_pkg.
module ljpf_mul import ljpf_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mul_req_t           req_i,
  input  logic signed [63:0] a_i,
  input  logic signed [63:0] b_i,
  output logic               busy_o,
  output logic               done_o,
  output logic signed [63:0] res_o,
  output logic [63:0]        prod_lo_o
);

  localparam int SH0 = 32;
  localparam int SH1 = FRAC_BITS + 8;

  logic [63:0]        ua_q, ub_q;
  logic               neg_q, sel_q, run_q, fin_q, done_q;
  logic [2:0]         cnt_q;
  logic [63:0]        pp_q;
  logic [127:0]       acc_q;
  logic signed [63:0] res_q;

  logic [31:0]  op_a, op_b;
  logic [127:0] pp_sh;
  logic [62:0]  mag;
  logic         sat0, sat1;

  always_comb begin
    op_a = cnt_q[1] ? ua_q[63:32] : ua_q[31:0];
    op_b = cnt_q[0] ? ub_q[63:32] : ub_q[31:0];
    case (cnt_q)
      3'd1:    pp_sh = {64'd0, pp_q};
      3'd2:    pp_sh = {32'd0, pp_q, 32'd0};
      3'd3:    pp_sh = {32'd0, pp_q, 32'd0};
      3'd4:    pp_sh = {pp_q, 64'd0};
      default: pp_sh = '0;
    endcase
    sat0 = |acc_q[127:63+SH0];
    sat1 = |acc_q[127:63+SH1];
    if (sel_q) begin
      mag = sat1 ? WMAX[62:0] : acc_q[SH1 +: 63];
    end else begin
      mag = sat0 ? WMAX[62:0] : acc_q[SH0 +: 63];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ua_q   <= '0;
      ub_q   <= '0;
      neg_q  <= 1'b0;
      sel_q  <= 1'b0;
      run_q  <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      pp_q   <= '0;
      acc_q  <= '0;
      res_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        ua_q  <= a_i[63] ? 64'(-a_i) : 64'(a_i);
        ub_q  <= b_i[63] ? 64'(-b_i) : 64'(b_i);
        neg_q <= a_i[63] ^ b_i[63];
        sel_q <= req_i.frac_shift;
        acc_q <= '0;
        cnt_q <= '0;
        run_q <= 1'b1;
      end else if (run_q) begin
        if (cnt_q != 3'd4) begin
          pp_q <= op_a * op_b;
        end
        acc_q <= acc_q + pp_sh;
        if (cnt_q == 3'd4) begin
          run_q <= 1'b0;
          fin_q <= 1'b1;
        end
        cnt_q <= cnt_q + 3'd1;
      end else if (fin_q) begin
        fin_q  <= 1'b0;
        done_q <= 1'b1;
        res_q  <= neg_q ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
      end
    end
  end

  assign busy_o    = run_q | fin_q;
  assign done_o    = done_q;
  assign res_o     = res_q;
  assign prod_lo_o = acc_q[63:0];

endmodule

/* sv/ljpf_div.sv */
// Bit-serial restoring divider, one quotient bit per cycle, with a
// sticky quotient overflow flag. Depends on ljpf_pkg.
module ljpf_div import ljpf_pkg::*; #(
  parameter int NUM_W = 65
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  div_req_t                   req_i,
  input  logic [NUM_W-1:0]           num_i,
  input  logic [$clog2(NUM_W+1)-1:0] iters_i,
  input  logic [63:0]                den_i,
  output logic                       busy_o,
  output logic                       done_o,
  output logic [63:0]                quo_o,
  output logic                       ovf_o,
  output logic [63:0]                rem_o
);

  localparam int IW = $clog2(NUM_W+1);

  logic [NUM_W-1:0] num_q;
  logic [63:0]      den_q, rem_q, quo_q;
  logic             ovf_q, run_q, done_q;
  logic [IW-1:0]    cnt_q;
  logic [64:0]      trial;
  logic             fits;

  always_comb begin
    trial = {rem_q, num_q[NUM_W-1]};
    fits  = trial >= {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q  <= '0;
      den_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
      ovf_q  <= 1'b0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        num_q <= num_i;
        den_q <= den_i;
        rem_q <= '0;
        quo_q <= '0;
        ovf_q <= 1'b0;
        cnt_q <= iters_i;
        run_q <= 1'b1;
      end else if (run_q) begin
        rem_q <= fits ? 64'(trial - {1'b0, den_q}) : trial[63:0];
        quo_q <= {quo_q[62:0], fits};
        ovf_q <= ovf_q | quo_q[63];
        num_q <= {num_q[NUM_W-2:0], 1'b0};
        cnt_q <= cnt_q - IW'(1);
        if (cnt_q == IW'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign busy_o = run_q;
  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign ovf_o  = ovf_q;
  assign rem_o  = rem_q;

endmodule
